[design/lpfd_pkg.sv]
`timescale 1ns / 1ps

package lpfd_pkg;

	// Default header length in bytes (legal range 12 to 16)
	localparam int unsigned HEADER_BYTES = 16;

	// Header layout: big-endian size in bytes 0..7, name length in bytes 8..11
	localparam int unsigned SIZE_BYTES = 8;
	localparam int unsigned NAME_END   = 12;

	typedef logic [7:0]  byte_t;
	typedef logic [63:0] size_t;
	typedef logic [31:0] name_len_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_DATA   = 2'd2
	} part_kind_t;

	// One result beat
	typedef struct packed {
		byte_t      byte_out;
		part_kind_t part_kind;
		logic       part_last;
		logic       header_done;
		size_t      size_of_file;
		name_len_t  length_of_name;
		logic       frame_done;
	} out_beat_t;

endpackage

[design/lpfd_if.sv]
`timescale 1ns / 1ps

interface lpfd_in_if;
	logic            valid;
	logic            ready;
	lpfd_pkg::byte_t stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface lpfd_out_if;
	logic                 valid;
	logic                 ready;
	lpfd_pkg::byte_t      byte_out;
	lpfd_pkg::part_kind_t part_kind;
	logic                 part_last;
	logic                 header_done;
	lpfd_pkg::size_t      size_of_file;
	lpfd_pkg::name_len_t  length_of_name;
	logic                 frame_done;

	modport source (output valid, output byte_out, output part_kind, output part_last,
		output header_done, output size_of_file, output length_of_name,
		output frame_done, input ready);
	modport sink (input valid, input byte_out, input part_kind, input part_last,
		input header_done, input size_of_file, input length_of_name,
		input frame_done, output ready);
endinterface

[design/lpfd_core.sv]
`timescale 1ns / 1ps

// Frame parser: phase state plus the tagging logic for one byte.
module lpfd_core #(
	parameter int unsigned HEADER_BYTES = lpfd_pkg::HEADER_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  lpfd_pkg::byte_t     stream_byte,
	output lpfd_pkg::out_beat_t beat
);

	localparam int unsigned IdxW = $clog2(HEADER_BYTES);
	localparam logic [IdxW:0] HdrLast = (IdxW + 1)'(HEADER_BYTES);
	localparam logic [IdxW:0] SizeEnd = (IdxW + 1)'(lpfd_pkg::SIZE_BYTES);
	localparam logic [IdxW:0] NameEnd = (IdxW + 1)'(lpfd_pkg::NAME_END);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_NAME   = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [IdxW-1:0]     idx_q, idx_n;
	lpfd_pkg::size_t     size_q, size_n;
	lpfd_pkg::name_len_t name_q, name_n;
	logic [63:0]         count_q, count_n;

	logic [63:0]         count_inc;
	logic [IdxW:0]       idx_inc;
	lpfd_pkg::size_t     size_base;
	lpfd_pkg::name_len_t name_base;

	assign count_inc = count_q + 64'd1;
	assign idx_inc   = {1'b0, idx_q} + {{IdxW{1'b0}}, 1'b1};
	// header byte 0 starts from cleared targets
	assign size_base = (idx_q == '0) ? '0 : size_q;
	assign name_base = (idx_q == '0) ? '0 : name_q;

	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		size_n  = size_q;
		name_n  = name_q;
		count_n = count_q;

		beat                = '0;
		beat.byte_out       = stream_byte;
		beat.part_kind      = lpfd_pkg::KIND_HEADER;

		case (phase_q)
			PH_NAME: begin
				beat.part_kind = lpfd_pkg::KIND_NAME;
				count_n        = count_inc;
				if (count_inc >= {32'd0, name_q}) begin
					beat.part_last = 1'b1;
					count_n        = '0;
					if (size_q == '0) begin
						beat.frame_done = 1'b1;
						phase_n         = PH_HEADER;
						idx_n           = '0;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				beat.part_kind = lpfd_pkg::KIND_DATA;
				count_n        = count_inc;
				if (count_inc >= size_q) begin
					beat.part_last  = 1'b1;
					beat.frame_done = 1'b1;
					count_n         = '0;
					phase_n         = PH_HEADER;
					idx_n           = '0;
				end
			end
			default: begin
				size_n = size_base;
				name_n = name_base;
				if ({1'b0, idx_q} < SizeEnd) begin
					size_n = {size_base[55:0], stream_byte};
				end else if ({1'b0, idx_q} < NameEnd) begin
					name_n = {name_base[23:0], stream_byte};
				end
				idx_n   = idx_inc[IdxW-1:0];
				phase_n = PH_HEADER;
				if (idx_inc >= HdrLast) begin
					beat.part_last      = 1'b1;
					beat.header_done    = 1'b1;
					beat.size_of_file   = size_n;
					beat.length_of_name = name_n;
					idx_n               = '0;
					count_n             = '0;
					if (name_n != '0) begin
						phase_n = PH_NAME;
					end else if (size_n != '0) begin
						phase_n = PH_DATA;
					end else begin
						beat.frame_done = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			size_q  <= '0;
			name_q  <= '0;
			count_q <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			size_q  <= size_n;
			name_q  <= name_n;
			count_q <= count_n;
		end
	end

endmodule

[design/lpfd_out_stage.sv]
`timescale 1ns / 1ps

// Result register; takes a new beat whenever empty or being drained.
module lpfd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpfd_pkg::out_beat_t beat,
	lpfd_out_if.source          out_ch
);

	logic                vld_s1;
	lpfd_pkg::out_beat_t beat_s1;

	assign in_ready = !vld_s1 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= beat;
		end
	end

	assign out_ch.valid          = vld_s1;
	assign out_ch.byte_out       = beat_s1.byte_out;
	assign out_ch.part_kind      = beat_s1.part_kind;
	assign out_ch.part_last      = beat_s1.part_last;
	assign out_ch.header_done    = beat_s1.header_done;
	assign out_ch.size_of_file   = beat_s1.size_of_file;
	assign out_ch.length_of_name = beat_s1.length_of_name;
	assign out_ch.frame_done     = beat_s1.frame_done;

endmodule

[design/length_prefixed_file_deframer_top.sv]
`timescale 1ns / 1ps

// Length-prefixed file deframer. Takes one stream byte per beat on in_ch and
// returns exactly one tagged beat on out_ch: header, filename or file data,
// with part_last, header_done and frame_done marks. A frame is a header of
// HEADER_BYTES bytes (big-endian 64-bit file size, big-endian 32-bit name
// length, then padding), then the filename bytes, then the file bytes. Empty
// parts are skipped; a frame with both lengths zero ends on its last header
// byte. size_of_file and length_of_name are valid only with header_done and
// read zero otherwise. One byte per clock unless out_ch stalls: the parse
// logic sits between the input handshake and a single result register, so
// out_ch.valid rises in the cycle after the accept. in_ch.ready is high
// whenever the result register is empty or being drained in the same cycle.
module length_prefixed_file_deframer_top #(
	parameter int unsigned HEADER_BYTES = lpfd_pkg::HEADER_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	lpfd_in_if.sink    in_ch,
	lpfd_out_if.source out_ch
);

	lpfd_pkg::out_beat_t beat;
	logic                stage_ready;
	logic                take;

	// a byte is taken when the result register can hold its beat
	assign in_ch.ready = stage_ready;
	assign take        = in_ch.valid && stage_ready;

	lpfd_core #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.stream_byte(in_ch.stream_byte),
		.beat       (beat)
	);

	lpfd_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(stage_ready),
		.beat    (beat),
		.out_ch  (out_ch)
	);

endmodule

[sim/lpfd_frame_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, predicts the tag of every accepted stream byte and
// compares it with the beats that come out.
module lpfd_frame_checker #(
	parameter int unsigned HEADER_BYTES = lpfd_pkg::HEADER_BYTES
) (
	input  logic clk,
	input  logic arst_n,
	lpfd_in_if   in_ch,
	lpfd_out_if  out_ch,
	output int   mismatch_count,
	output int   tags_outstanding
);

	typedef enum logic [1:0] {
		IN_HEADER = 2'd0,
		IN_NAME   = 2'd1,
		IN_DATA   = 2'd2
	} parse_phase_t;

	parse_phase_t        parse_phase;
	int unsigned         hdr_pos;
	lpfd_pkg::size_t     size_goal;
	lpfd_pkg::name_len_t name_goal;
	logic [63:0]         taken_count;

	lpfd_pkg::out_beat_t expected_tags[$];

	// Advances the parser by one stream byte and returns its tag.
	function automatic lpfd_pkg::out_beat_t tag_stream_byte(lpfd_pkg::byte_t b);
		lpfd_pkg::out_beat_t r;
		r = '0;
		r.byte_out = b;
		r.part_kind = lpfd_pkg::KIND_HEADER;
		case (parse_phase)
			IN_NAME: begin
				r.part_kind = lpfd_pkg::KIND_NAME;
				taken_count++;
				if (taken_count >= {32'd0, name_goal}) begin
					r.part_last = 1'b1;
					taken_count = '0;
					if (size_goal == '0) begin
						r.frame_done = 1'b1;
						parse_phase = IN_HEADER;
						hdr_pos = 0;
					end else begin
						parse_phase = IN_DATA;
					end
				end
			end
			IN_DATA: begin
				r.part_kind = lpfd_pkg::KIND_DATA;
				taken_count++;
				if (taken_count >= size_goal) begin
					r.part_last = 1'b1;
					r.frame_done = 1'b1;
					taken_count = '0;
					parse_phase = IN_HEADER;
					hdr_pos = 0;
				end
			end
			default: begin
				if (hdr_pos == 0) begin
					size_goal = '0;
					name_goal = '0;
				end
				if (hdr_pos < lpfd_pkg::SIZE_BYTES)
					size_goal = {size_goal[55:0], b};
				else if (hdr_pos < lpfd_pkg::NAME_END)
					name_goal = {name_goal[23:0], b};
				hdr_pos++;
				if (hdr_pos >= HEADER_BYTES) begin
					r.part_last = 1'b1;
					r.header_done = 1'b1;
					r.size_of_file = size_goal;
					r.length_of_name = name_goal;
					hdr_pos = 0;
					taken_count = '0;
					if (name_goal != '0) begin
						parse_phase = IN_NAME;
					end else if (size_goal != '0) begin
						parse_phase = IN_DATA;
					end else begin
						r.frame_done = 1'b1;
						parse_phase = IN_HEADER;
					end
				end else begin
					parse_phase = IN_HEADER;
				end
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lpfd_pkg::out_beat_t exp_tag;
		if (!arst_n) begin
			parse_phase = IN_HEADER;
			hdr_pos = 0;
			size_goal = '0;
			name_goal = '0;
			taken_count = '0;
			expected_tags.delete();
			mismatch_count = 0;
		end else begin
			// Result first: a beat leaving now belongs to an earlier byte.
			if (out_ch.valid && out_ch.ready) begin
				if (expected_tags.size() == 0) begin
					$error("result beat 0x%0h with nothing expected", out_ch.byte_out);
					mismatch_count++;
				end else begin
					exp_tag = expected_tags.pop_front();
					compare_field("byte_out", exp_tag.byte_out, out_ch.byte_out);
					compare_field("part_kind", exp_tag.part_kind, out_ch.part_kind);
					compare_field("part_last", exp_tag.part_last, out_ch.part_last);
					compare_field("header_done", exp_tag.header_done, out_ch.header_done);
					compare_field("size_of_file", exp_tag.size_of_file,
						out_ch.size_of_file);
					compare_field("length_of_name", exp_tag.length_of_name,
						out_ch.length_of_name);
					compare_field("frame_done", exp_tag.frame_done, out_ch.frame_done);
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_tags.push_back(tag_stream_byte(in_ch.stream_byte));
		end
		tags_outstanding = expected_tags.size();
	end

endmodule

[sim/length_prefixed_file_deframer_top_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the deframer. Checking lives in lpfd_frame_checker.
module length_prefixed_file_deframer_top_tb;

	logic clk;
	logic arst_n;

	lpfd_in_if  in_ch();
	lpfd_out_if out_ch();

	int mismatch_count;
	int tags_outstanding;

	// Idle odds in percent for the byte sender and the result taker
	int unsigned send_gap_pct;
	int unsigned take_gap_pct;

	// Set at each rising edge when the stream beat was taken; read at the
	// following falling edge, so the sender never races the block's ready.
	logic byte_taken;
	int   bytes_sent;

	length_prefixed_file_deframer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	lpfd_frame_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.out_ch           (out_ch),
		.mismatch_count   (mismatch_count),
		.tags_outstanding (tags_outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		byte_taken <= in_ch.valid && in_ch.ready;
	end

	// Result side: held off in reset, then stalls at random, one decision per cycle
	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= ($urandom_range(99) >= take_gap_pct);
		else
			out_ch.ready <= 1'b0;
	end

	// Hands one byte over; called and left on a falling edge. valid stays
	// high when the next byte follows with no gap.
	task automatic send_byte(input lpfd_pkg::byte_t b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.stream_byte <= b;
		do
			@(negedge clk);
		while (!byte_taken);
		bytes_sent++;
	endtask

	// Header with big-endian size and name length, random padding, then
	// random filename and file bytes.
	task automatic send_file(input lpfd_pkg::size_t file_len,
		input lpfd_pkg::name_len_t name_len);
		for (int i = 0; i < lpfd_pkg::SIZE_BYTES; i++)
			send_byte(file_len[63 - 8 * i -: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(name_len[31 - 8 * i -: 8]);
		for (int i = lpfd_pkg::NAME_END; i < lpfd_pkg::HEADER_BYTES; i++)
			send_byte(lpfd_pkg::byte_t'($urandom_range(255)));
		for (longint i = 0; i < name_len; i++)
			send_byte(lpfd_pkg::byte_t'($urandom_range(255)));
		for (longint i = 0; i < file_len; i++)
			send_byte(lpfd_pkg::byte_t'($urandom_range(255)));
	endtask

	// Holds the stream off until every tag has come back.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (tags_outstanding != 0);
	endtask

	task automatic random_files(input int upto);
		lpfd_pkg::size_t     file_len;
		lpfd_pkg::name_len_t name_len;
		while (bytes_sent < upto) begin
			// Empty parts come often so every skip path gets hit
			name_len = lpfd_pkg::name_len_t'(
				($urandom_range(99) < 30) ? 0 : $urandom_range(1, 8));
			file_len = lpfd_pkg::size_t'(
				($urandom_range(99) < 30) ? 0 : $urandom_range(1, 24));
			send_file(file_len, name_len);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.stream_byte = '0;
		bytes_sent = 0;
		send_gap_pct = 0;
		take_gap_pct = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty frame with all-ones padding, so it ends on its
		// last header byte; then one random filename byte and one random
		// data byte.
		for (int i = 0; i < lpfd_pkg::NAME_END; i++)
			send_byte(8'h00);
		for (int i = lpfd_pkg::NAME_END; i < lpfd_pkg::HEADER_BYTES; i++)
			send_byte(8'hFF);
		send_file(64'd1, 32'd1);

		// Random frames in three idle mixes, emptying the pipe between them
		send_gap_pct = 26;
		take_gap_pct = 63;
		random_files(bytes_sent + 180);
		drain_results();

		send_gap_pct = 63;
		take_gap_pct = 26;
		random_files(bytes_sent + 180);
		drain_results();

		send_gap_pct = 0;
		take_gap_pct = 0;
		random_files(bytes_sent + 180);

		// Tail: a header with every size and name-length bit set, plus a few
		// name bytes. The frame never ends, so it has to come last.
		for (int i = 0; i < lpfd_pkg::HEADER_BYTES; i++)
			send_byte(8'hFF);
		repeat (3) send_byte(lpfd_pkg::byte_t'($urandom_range(255)));

		in_ch.valid <= 1'b0;
		while (tags_outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
